>>> sv/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// shared types and register codes for the substring removal filter
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int PAT_BITS  = 64;
  localparam int LEN_BITS  = 4;
  localparam int CFG_IDX_W = 1;

  typedef logic [7:0]           char_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_PATTERN_BYTES  = 1'd0;
  localparam cfg_idx_t REG_PATTERN_LENGTH = 1'd1;

endpackage

>>> sv/srf_queue.sv
// ----------------------------------------------------------------------------
// srf_queue
// two-entry queue of emit bundles between the front and back parts
// ----------------------------------------------------------------------------
module srf_queue #(
  parameter int WIDTH = 77
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");

endmodule

>>> sv/srf_front.sv
// ----------------------------------------------------------------------------
// srf_front
// accepts bytes, keeps the pending window and decides what is emitted
// ----------------------------------------------------------------------------
module srf_front #(
  parameter  int MAX_PATTERN = 8,
  localparam int CW          = $clog2(MAX_PATTERN + 1),
  localparam int BW          = 8 * MAX_PATTERN + CW + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  srf_pkg::char_t                in_byte,
  input  logic                          in_last,
  input  logic [srf_pkg::PAT_BITS-1:0]  pattern_bytes,
  input  logic [srf_pkg::LEN_BITS-1:0]  pattern_length,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [BW-1:0]                 q_data
);

  import srf_pkg::*;

  char_t                  win [MAX_PATTERN];
  char_t                  wa  [MAX_PATTERN];
  char_t                  sh  [MAX_PATTERN];
  char_t                  nw  [MAX_PATTERN];
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [CW-1:0]          len;
  logic [CW-1:0]          c1;
  logic [CW-1:0]          k;
  logic [CW-1:0]          e;
  logic                   full;
  logic                   match;
  logic                   accept;
  logic [MAX_PATTERN-1:0] mism;
  logic [8*MAX_PATTERN-1:0] flat;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // clamp length into 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len = CW'(1);
    end else if (pattern_length > LEN_BITS'(MAX_PATTERN)) begin
      len = CW'(MAX_PATTERN);
    end else begin
      len = CW'(pattern_length);
    end
  end

  // window with the new byte appended
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wa[i] = (CW'(i) == count) ? in_byte : win[i];
      flat[8*i +: 8] = wa[i];
    end
  end

  assign c1   = count + 1'b1;
  assign full = (c1 >= len);
  assign k    = (c1 > len) ? (c1 - len) : '0;

  // youngest len bytes aligned to the pattern
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sh[i] = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ((CW+1)'(j) == (CW+1)'(i) + {1'b0, k}) begin
          sh[i] = wa[j];
        end
      end
      mism[i] = (CW'(i) < len) && (sh[i] != pattern_bytes[8*i +: 8]);
    end
  end

  assign match = full && !(|mism);

  // number of oldest bytes to emit
  always_comb begin
    if (in_last) begin
      e = match ? k : c1;
    end else if (full) begin
      e = match ? k : (k + 1'b1);
    end else begin
      e = '0;
    end
  end

  // window after dropping the emitted bytes
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      nw[i] = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if ((CW+1)'(j) == (CW+1)'(i) + {1'b0, e}) begin
          nw[i] = wa[j];
        end
      end
    end
  end

  assign count_next = (in_last || match) ? '0 : (c1 - e);
  assign q_push     = accept && (in_last || (e != '0));
  assign q_data     = {in_last, e, flat};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= nw;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> count == '0)
    else $error("window not cleared after last byte");
  a_count_room: assert property (@(posedge clk) disable iff (rst)
    count < CW'(MAX_PATTERN))
    else $error("pending count leaves no room");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("bundle pushed while queue full");

endmodule

>>> sv/srf_back.sv
// ----------------------------------------------------------------------------
// srf_back
// serialises emit bundles into single result transfers
// ----------------------------------------------------------------------------
module srf_back #(
  parameter  int MAX_PATTERN = 8,
  localparam int CW          = $clog2(MAX_PATTERN + 1),
  localparam int IW          = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int BW          = 8 * MAX_PATTERN + CW + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  logic [BW-1:0]  q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output srf_pkg::char_t out_byte,
  output logic           byte_valid,
  output logic           out_last
);

  import srf_pkg::*;

  logic          hd_last;
  logic [CW-1:0] hd_cnt;
  logic [IW-1:0] pos;
  logic          take;
  logic          fire;
  logic          fin;
  char_t         sel;

  assign hd_last = q_data[BW-1];
  assign hd_cnt  = q_data[BW-2 -: CW];
  assign sel     = q_data[8*pos +: 8];

  assign take  = !out_valid || !out_stall;
  assign fire  = take && q_valid;
  assign fin   = (hd_cnt == '0) || ((CW'(pos) + 1'b1) == hd_cnt);
  assign q_pop = fire && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (take) begin
        out_valid <= q_valid;
      end
      if (fire) begin
        pos <= fin ? '0 : (pos + 1'b1);
      end
    end
  end

  // empty end marker when the bundle holds no byte
  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte   <= (hd_cnt == '0) ? '0 : sel;
      byte_valid <= (hd_cnt != '0);
      out_last   <= hd_last && fin;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_last)
    else $error("empty result without last flag");
  a_pos_rewinds: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> pos == '0)
    else $error("position not rewound after bundle");
  a_pos_in_bundle: assert property (@(posedge clk) disable iff (rst)
    q_valid && hd_cnt != '0 |-> CW'(pos) < hd_cnt)
    else $error("position beyond bundle");

endmodule

>>> sv/substring_removal_filter.sv
// ----------------------------------------------------------------------------
// substring_removal_filter
// streaming deletion of every leftmost non-overlapping pattern occurrence
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low and deletes each leftmost,
// non-overlapping copy of a 1 to 8 byte pattern; kept bytes leave in input
// order, one result transfer per cycle while out_stall is low. The front
// part appends each byte to a window of pending bytes, compares it with the
// pattern in parallel and hands the bytes to emit to a two-entry queue as one
// bundle; the back part drains a bundle one byte per cycle, while out_stall
// is low, into an output register. In steady state a byte yields at most one
// result. On the byte marked last the whole pending window is flushed, so
// that byte yields up to MAX_PATTERN results; meanwhile the queue holds one
// more bundle behind it and bytes that emit nothing keep flowing, but once
// that bundle is queued the input stalls until the flush has drained. A
// string whose kept bytes all went earlier ends with one empty result
// (byte_valid low, out_last high). Configuration writes are always taken
// (cfg_ready is tied high) and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module substring_removal_filter #(
  parameter  int MAX_PATTERN = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // input byte channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  srf_pkg::char_t                in_byte,
  input  logic                          in_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output srf_pkg::char_t                out_byte,
  output logic                          byte_valid,
  output logic                          out_last,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  srf_pkg::cfg_idx_t             cfg_index,
  input  logic [srf_pkg::PAT_BITS-1:0]  cfg_data
);

  import srf_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int BW = 8 * MAX_PATTERN + CW + 1;

  logic [PAT_BITS-1:0] pattern_bytes;
  logic [LEN_BITS-1:0] pattern_length;
  logic                q_full;
  logic                q_push;
  logic [BW-1:0]       q_wdata;
  logic                q_pop;
  logic                q_valid;
  logic [BW-1:0]       q_head;

  // configuration registers, one write transfer per cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= LEN_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: window, compare and emit decision
  srf_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .pattern_bytes  (pattern_bytes),
    .pattern_length (pattern_length),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  // bundles waiting for the serialiser
  srf_queue #(
    .WIDTH (BW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // back: one result transfer per cycle while out_stall is low
  srf_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last)
  );

endmodule
